FILE: src/opcode_command_deframer_defines.svh
// ----------------------------------------------------------------------------
// opcode_command_deframer_defines.svh
// Assertion macros shared by the command deframer RTL.
// ----------------------------------------------------------------------------
`ifndef OPCODE_COMMAND_DEFRAMER_DEFINES_SVH
`define OPCODE_COMMAND_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while the active-low reset is asserted.
`define OCD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while the active-low reset is asserted.
`define OCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/occ_pkg.sv
// ----------------------------------------------------------------------------
// occ_pkg
// Types, constants and the opcode length table of the command deframer.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;
    localparam int LEN_W  = 5;

    // Opcode whose length is carried in the command itself.
    localparam logic [BYTE_W-1:0] OP_VARIABLE = 8'h21;
    // Header bytes of a variable command, and the position of its length byte.
    localparam logic [POS_W-1:0]  VAR_HEADER  = 9'd6;
    localparam logic [POS_W-1:0]  VAR_LEN_POS = 9'd5;
    localparam logic [LEN_W-1:0]  LEN_UNKNOWN = 5'd0;
    localparam logic [LEN_W-1:0]  LEN_SINGLE  = 5'd1;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] cmd_opcode;
        logic [POS_W-1:0]  byte_position;
        logic              frame_start;
        logic              frame_end;
        logic              discarded;
    } t_result;

    // Total length of a fixed-length command, opcode included; zero for a
    // byte that is not a known fixed opcode.
    function automatic logic [LEN_W-1:0] fixed_length(input logic [BYTE_W-1:0] op);
        logic [LEN_W-1:0] len;
        case (op) inside
            8'h01, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0C, 8'h11, 8'h14, 8'h15,
            8'h19, 8'h22, 8'h23, 8'h24:           len = 5'd1;
            8'h03, 8'h05, 8'h0E, 8'h0F, 8'h10,
            8'h13, 8'h16:                         len = 5'd2;
            8'h02:                                len = 5'd3;
            8'h0A:                                len = 5'd4;
            8'h25:                                len = 5'd5;
            8'h17, 8'h18:                         len = 5'd8;
            8'h20:                                len = 5'd9;
            8'h12:                                len = 5'd18;
            8'h0D:                                len = 5'd27;
            default:                              len = LEN_UNKNOWN;
        endcase
        return len;
    endfunction

endpackage

FILE: src/occ_tracker.sv
// ----------------------------------------------------------------------------
// occ_tracker
// Command framing state and the tag computation for one received byte.
// ----------------------------------------------------------------------------
module occ_tracker
    import occ_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_take,
    input  logic [BYTE_W-1:0] i_rx_byte,
    output t_result           o_result
);

    logic              r_in_cmd,  n_in_cmd;
    logic [BYTE_W-1:0] r_opcode,  n_opcode;
    logic [POS_W-1:0]  r_count,   n_count;
    logic [POS_W-1:0]  r_need,    n_need;
    logic              r_pending, n_pending;
    logic [LEN_W-1:0]  fix_len;
    logic [POS_W:0]    next_pos;

    assign fix_len  = fixed_length(i_rx_byte);
    assign next_pos = {1'b0, r_count} + {{POS_W{1'b0}}, 1'b1};

    always_comb begin
        o_result           = '0;
        o_result.data_byte = i_rx_byte;
        n_in_cmd  = r_in_cmd;
        n_opcode  = r_opcode;
        n_count   = r_count;
        n_need    = r_need;
        n_pending = r_pending;

        if (!r_in_cmd) begin
            if (i_rx_byte == OP_VARIABLE) begin
                o_result.cmd_opcode  = i_rx_byte;
                o_result.frame_start = 1'b1;
                n_in_cmd  = 1'b1;
                n_opcode  = i_rx_byte;
                n_count   = POS_W'(1);
                n_need    = '0;
                n_pending = 1'b1;
            end else if (fix_len == LEN_UNKNOWN) begin
                o_result.discarded = 1'b1;
            end else begin
                o_result.cmd_opcode  = i_rx_byte;
                o_result.frame_start = 1'b1;
                if (fix_len == LEN_SINGLE) begin
                    o_result.frame_end = 1'b1;
                end else begin
                    n_in_cmd  = 1'b1;
                    n_opcode  = i_rx_byte;
                    n_count   = POS_W'(1);
                    n_need    = POS_W'(fix_len);
                    n_pending = 1'b0;
                end
            end
        end else begin
            o_result.cmd_opcode    = r_opcode;
            o_result.byte_position = r_count;
            if (r_pending && r_count == VAR_LEN_POS) begin
                n_need    = VAR_HEADER + POS_W'(i_rx_byte);
                n_pending = 1'b0;
            end
            if (!n_pending && next_pos >= {1'b0, n_need}) begin
                o_result.frame_end = 1'b1;
                n_in_cmd = 1'b0;
                n_count  = '0;
            end else begin
                n_count = next_pos[POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_cmd  <= 1'b0;
            r_opcode  <= '0;
            r_count   <= '0;
            r_need    <= '0;
            r_pending <= 1'b0;
        end else if (i_take) begin
            r_in_cmd  <= n_in_cmd;
            r_opcode  <= n_opcode;
            r_count   <= n_count;
            r_need    <= n_need;
            r_pending <= n_pending;
        end
    end

endmodule

FILE: src/opcode_command_deframer.sv
// ----------------------------------------------------------------------------
// opcode_command_deframer
// Splits a host byte stream into opcode-led commands and tags every byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Handshake                 Payload
//   rx        in          i_rx_valid / o_rx_stall   i_rx_byte
//   out       out         o_out_valid / i_out_stall o_data_byte, o_cmd_opcode,
//                                                   o_byte_position, o_frame_start,
//                                                   o_frame_end, o_discarded
//
// The framing state and the length lookup settle in a single pass, and the
// tagged byte lands in the output register on the edge that accepts the
// transfer, so it is visible in the cycle after that edge.
// A new byte is accepted in every cycle unless the output register is full
// and the downstream side stalls it; the output register then holds.
// Reset is synchronous and active low. It clears the framing state, so the
// first byte after reset is taken as an opcode, and empties the output.
// ----------------------------------------------------------------------------
module opcode_command_deframer
    import occ_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    input  logic              i_rx_valid,
    output logic              o_rx_stall,
    input  logic [BYTE_W-1:0] i_rx_byte,

    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [BYTE_W-1:0] o_data_byte,
    output logic [BYTE_W-1:0] o_cmd_opcode,
    output logic [POS_W-1:0]  o_byte_position,
    output logic              o_frame_start,
    output logic              o_frame_end,
    output logic              o_discarded
);

`include "opcode_command_deframer_defines.svh"

    logic    take;
    t_result result;
    logic    r_out_valid;
    t_result r_out;

    // The input stalls only when the output register is occupied and the
    // downstream side will not take it this cycle.
    assign o_rx_stall = r_out_valid && i_out_stall;
    assign take       = i_rx_valid && !o_rx_stall;

    // The tracker owns the framing state and advances it on each transfer.
    occ_tracker u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (take),
        .i_rx_byte (i_rx_byte),
        .o_result  (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Payload needs no reset; it is only loaded on a transfer.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_out <= result;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_data_byte     = r_out.data_byte;
    assign o_cmd_opcode    = r_out.cmd_opcode;
    assign o_byte_position = r_out.byte_position;
    assign o_frame_start   = r_out.frame_start;
    assign o_frame_end     = r_out.frame_end;
    assign o_discarded     = r_out.discarded;

    // A full, stalled output register must block the input side.
    `OCD_ASSERT_IMPL(a_full_blocks_input, i_clk, i_rst_n,
        r_out_valid && i_out_stall, o_rx_stall)
    // Every accepted byte shows up as a valid result on the next cycle.
    `OCD_ASSERT_NEXT(a_take_gives_result, i_clk, i_rst_n,
        take, o_out_valid)
    // A discarded byte carries no framing tags.
    `OCD_ASSERT_IMPL(a_discard_clean, i_clk, i_rst_n,
        o_out_valid && o_discarded,
        !o_frame_start && !o_frame_end && o_byte_position == '0 && o_cmd_opcode == '0)
    // An opcode byte always sits at position zero.
    `OCD_ASSERT_IMPL(a_start_at_zero, i_clk, i_rst_n,
        o_out_valid && o_frame_start, o_byte_position == '0 && !o_discarded)

endmodule

FILE: dv/opcode_command_deframer_test.sv
// ----------------------------------------------------------------------------
// opcode_command_deframer_test
// Self-checking regression of the command deframer. A byte stream of
// well-formed commands with random payloads, mixed with noise bytes, is
// pushed through the block under changing idle and stall patterns. Each
// tagged output byte is compared against a framing predictor kept in step
// with the accepted input transfers.
// ----------------------------------------------------------------------------
module opcode_command_deframer_test;
    import occ_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the run.
    localparam int CYCLE_LIMIT  = 400000;
    // Length of the long receiver hold-off that fills the block.
    localparam int HOLD_CYCLES  = 120;
    // Cycles allowed after the last result before the verdict.
    localparam int DRAIN_CYCLES = 10;
    // Bytes of random traffic queued per idling phase.
    localparam int PHASE_BYTES  = 460;

    // A few opcodes used by name in the directed part.
    localparam logic [BYTE_W-1:0] OP_SINGLE_BYTE = 8'h01;
    localparam logic [BYTE_W-1:0] OP_TWO_BYTE    = 8'h03;
    localparam logic [BYTE_W-1:0] OP_NOT_KNOWN   = 8'h26;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_rx_valid;
    logic              o_rx_stall;
    logic [BYTE_W-1:0] i_rx_byte;
    logic              o_out_valid;
    logic              i_out_stall;
    logic [BYTE_W-1:0] o_data_byte;
    logic [BYTE_W-1:0] o_cmd_opcode;
    logic [POS_W-1:0]  o_byte_position;
    logic              o_frame_start;
    logic              o_frame_end;
    logic              o_discarded;

    opcode_command_deframer u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_rx_valid     (i_rx_valid),
        .o_rx_stall     (o_rx_stall),
        .i_rx_byte      (i_rx_byte),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_data_byte    (o_data_byte),
        .o_cmd_opcode   (o_cmd_opcode),
        .o_byte_position(o_byte_position),
        .o_frame_start  (o_frame_start),
        .o_frame_end    (o_frame_end),
        .o_discarded    (o_discarded)
    );

    // Bytes waiting to be offered, and tagged bytes the block still owes.
    logic [BYTE_W-1:0] pending_bytes[$];
    t_result           frame_tags_due[$];

    // Opcodes that start a command of fixed length, collected from the table.
    logic [BYTE_W-1:0] fixed_opcodes[$];

    // Idling knobs, set per phase by the stimulus process.
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // Long hold-off: requested by the stimulus, counted down in its own process.
    logic hold_req  = 1'b0;
    int   hold_left = 0;

    // Set at each rising edge when an input transfer took place.
    logic rx_taken = 1'b0;

    int error_count = 0;
    int cycle_count = 0;

    // Framing state of the predictor.
    logic              cmd_open;
    logic [BYTE_W-1:0] open_opcode;
    int                next_pos;
    int                total_len;
    logic              len_awaited;

    // Coverage tallies for the summary.
    int bytes_seen     = 0;
    int starts_seen    = 0;
    int ends_seen      = 0;
    int discards_seen  = 0;
    int var_cmds_seen  = 0;
    int deepest_pos    = 0;
    int stalled_offers = 0;

    // Total command length by opcode, opcode byte included. Zero marks a byte
    // that does not open a fixed-length command.
    function automatic int cmd_total_len(input logic [BYTE_W-1:0] op);
        case (op)
            8'h01, 8'h07, 8'h08, 8'h09, 8'h0B, 8'h0C, 8'h11,
            8'h14, 8'h15, 8'h19, 8'h22, 8'h23, 8'h24: return 1;
            8'h03, 8'h05, 8'h0E, 8'h0F, 8'h10, 8'h13, 8'h16: return 2;
            8'h02: return 3;
            8'h0A: return 4;
            8'h25: return 5;
            8'h17, 8'h18: return 8;
            8'h20: return 9;
            8'h12: return 18;
            8'h0D: return 27;
            default: return 0;
        endcase
    endfunction

    // Advances the framing state by one accepted byte and queues the tags
    // that the block must attach to it.
    task automatic predict_frame_tags(input logic [BYTE_W-1:0] b);
        t_result tags;
        int      len;
        tags = '0;
        tags.data_byte = b;
        if (!cmd_open) begin
            if (b == OP_VARIABLE) begin
                // The length of a variable command is unknown until its
                // length byte arrives.
                tags.cmd_opcode  = b;
                tags.frame_start = 1'b1;
                cmd_open    = 1'b1;
                open_opcode = b;
                next_pos    = 1;
                total_len   = 0;
                len_awaited = 1'b1;
                var_cmds_seen++;
            end else begin
                len = cmd_total_len(b);
                if (len == 0) begin
                    // Not an opcode: the byte is dropped and the state holds.
                    tags.discarded = 1'b1;
                end else begin
                    tags.cmd_opcode  = b;
                    tags.frame_start = 1'b1;
                    if (len == 1) begin
                        tags.frame_end = 1'b1;
                    end else begin
                        cmd_open    = 1'b1;
                        open_opcode = b;
                        next_pos    = 1;
                        total_len   = len;
                        len_awaited = 1'b0;
                    end
                end
            end
        end else begin
            tags.cmd_opcode    = open_opcode;
            tags.byte_position = POS_W'(next_pos);
            if (len_awaited && next_pos == int'(VAR_LEN_POS)) begin
                total_len   = int'(VAR_HEADER) + int'(b);
                len_awaited = 1'b0;
            end
            if (!len_awaited && next_pos + 1 >= total_len) begin
                tags.frame_end = 1'b1;
                cmd_open = 1'b0;
                next_pos = 0;
            end else begin
                next_pos++;
            end
            if (next_pos > deepest_pos) begin
                deepest_pos = next_pos;
            end
        end
        bytes_seen++;
        if (tags.frame_start) starts_seen++;
        if (tags.frame_end) ends_seen++;
        if (tags.discarded) discards_seen++;
        frame_tags_due.push_back(tags);
    endtask

    // Queues one well-formed command with a random payload. For a variable
    // command, data_len is the value of its length byte.
    task automatic queue_command(input logic [BYTE_W-1:0] op, input int data_len);
        int len;
        pending_bytes.push_back(op);
        if (op == OP_VARIABLE) begin
            for (int i = 1; i < int'(VAR_LEN_POS); i++) begin
                pending_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
            pending_bytes.push_back(BYTE_W'(data_len));
            for (int i = 0; i < data_len; i++) begin
                pending_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
        end else begin
            len = cmd_total_len(op);
            for (int i = 1; i < len; i++) begin
                pending_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // Mostly whole commands with random content; the rest is stray bytes
    // that force the block to resynchronize.
    task automatic queue_traffic(input int n_bytes);
        int goal;
        int pick;
        int data_len;
        goal = pending_bytes.size() + n_bytes;
        while (pending_bytes.size() < goal) begin
            pick = $urandom_range(99);
            if (pick < 18) begin
                // Short variable commands by far outnumber long ones.
                data_len = ($urandom_range(24) == 0) ? $urandom_range(255)
                                                     : $urandom_range(12);
                queue_command(OP_VARIABLE, data_len);
            end else if (pick < 82) begin
                queue_command(fixed_opcodes[$urandom_range(fixed_opcodes.size() - 1)], 0);
            end else begin
                pending_bytes.push_back(BYTE_W'($urandom_range(255)));
            end
        end
    endtask

    // Waits until every queued byte has been taken and every result checked.
    task automatic drain_all;
        while (pending_bytes.size() != 0 || i_rx_valid || frame_tags_due.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            error_count++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Cycle counter and watchdog.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("opcode_command_deframer regression: fail");
            $finish;
        end
    end

    // Input side: note each accepted transfer and predict its tags.
    always @(posedge i_clk) begin
        rx_taken <= i_rst_n && i_rx_valid && !o_rx_stall;
        if (i_rst_n && i_rx_valid) begin
            if (o_rx_stall) begin
                stalled_offers++;
            end else begin
                predict_frame_tags(i_rx_byte);
            end
        end
    end

    // Driver: offers the next pending byte at the falling edge once the
    // previous transfer is done. A stalled byte stays on the port unchanged,
    // and the decision to idle never looks at the stall.
    always @(negedge i_clk) begin
        if (i_rst_n && (!i_rx_valid || rx_taken)) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_rx_valid <= 1'b1;
                i_rx_byte  <= pending_bytes.pop_front();
            end else begin
                i_rx_valid <= 1'b0;
            end
        end
    end

    // Hold-off counter for the long receiver stall.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (hold_req) begin
            hold_left <= HOLD_CYCLES;
        end
    end

    // Receiver: stalls at random, or for the whole hold-off.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            i_out_stall <= (hold_left != 0) || ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: each output transfer is checked against the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (frame_tags_due.size() == 0) begin
                $error("output transfer with no prediction pending: data_byte 0x%0h",
                       o_data_byte);
                error_count++;
            end else begin
                want = frame_tags_due.pop_front();
                check_field("data_byte", want.data_byte, o_data_byte);
                check_field("cmd_opcode", want.cmd_opcode, o_cmd_opcode);
                check_field("byte_position", want.byte_position, o_byte_position);
                check_field("frame_start", want.frame_start, o_frame_start);
                check_field("frame_end", want.frame_end, o_frame_end);
                check_field("discarded", want.discarded, o_discarded);
            end
        end
    end

    // Stimulus: reset, a short directed stream, then four idling phases.
    initial begin
        int settle;
        i_rst_n     = 1'b0;
        i_rx_valid  = 1'b0;
        i_rx_byte   = '0;
        i_out_stall = 1'b0;
        cmd_open    = 1'b0;
        open_opcode = '0;
        next_pos    = 0;
        total_len   = 0;
        len_awaited = 1'b0;
        for (int v = 0; v < 256; v++) begin
            if (cmd_total_len(BYTE_W'(v)) != 0) begin
                fixed_opcodes.push_back(BYTE_W'(v));
            end
        end

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: stray bytes at both ends of the byte range, a one-byte
        // command, a two-byte command, a variable command with zero data
        // whose length byte closes it, one with a single data byte, and a
        // stray byte right after a command ends.
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(OP_SINGLE_BYTE);
        pending_bytes.push_back(OP_TWO_BYTE);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(OP_VARIABLE);
        pending_bytes.push_back(8'hFF);
        pending_bytes.push_back(8'h00);
        pending_bytes.push_back(8'hAA);
        pending_bytes.push_back(8'h55);
        pending_bytes.push_back(8'h00);
        queue_command(OP_VARIABLE, 1);
        pending_bytes.push_back(OP_NOT_KNOWN);
        drain_all();

        // Phase 1: no idling on either side. The longest variable command
        // goes first, and a long receiver hold-off fills the block while
        // the sender keeps offering.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_command(OP_VARIABLE, 255);
        queue_traffic(PHASE_BYTES - 261);
        hold_req = 1'b1;
        while (hold_left == 0) @(posedge i_clk);
        hold_req = 1'b0;
        drain_all();

        // Phase 2: sender mostly idle.
        send_idle_pct  = 85;
        recv_stall_pct = 0;
        queue_traffic(PHASE_BYTES);
        drain_all();

        // Phase 3: receiver mostly stalling.
        send_idle_pct  = 0;
        recv_stall_pct = 85;
        queue_traffic(PHASE_BYTES);
        drain_all();

        // Phase 4: both sides pause now and then.
        send_idle_pct  = 28;
        recv_stall_pct = 28;
        queue_traffic(PHASE_BYTES);
        drain_all();

        // Allow any stray late output to show up before the verdict.
        settle = 0;
        while (settle < DRAIN_CYCLES) begin
            @(posedge i_clk);
            settle++;
        end

        $display("covered %0d bytes: %0d commands opened, %0d closed, %0d variable, %0d discards",
                 bytes_seen, starts_seen, ends_seen, var_cmds_seen, discards_seen);
        $display("deepest byte position %0d, %0d stalled input offers, %0d mismatches",
                 deepest_pos, stalled_offers, error_count);
        if (error_count == 0 && frame_tags_due.size() == 0) begin
            $display("opcode_command_deframer regression: pass");
        end else begin
            $display("opcode_command_deframer regression: fail");
        end
        $finish;
    end

endmodule
